>>> hw/rtl/rmnle_pkg.sv
package rmnle_pkg;

  localparam int unsigned ENERGY_BITS         = 32;
  localparam int unsigned LEVEL_FRAC_BITS_DEF = 16;
  localparam int unsigned AGE_BITS            = 14;
  localparam int unsigned WIN_BITS            = 12;
  localparam int unsigned RATE_BITS           = 16;
  localparam int unsigned CFG_IDX_BITS        = 2;
  localparam int unsigned CFG_DATA_BITS       = 32;

  localparam logic [RATE_BITS-1:0]   RATE_ONE        = 16'h8000;
  localparam logic [ENERGY_BITS-1:0] MAX_NOISE_RST   = 32'd60000000;
  localparam logic [ENERGY_BITS-1:0] MIN_NOISE_RST   = 32'd16;
  localparam logic [WIN_BITS-1:0]    WINDOW_LEN_RST  = 12'd333;
  localparam logic [RATE_BITS-1:0]   SMOOTH_RATE_RST = 16'd6554;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MAX_NOISE   = 2'd0,
    CFG_MIN_NOISE   = 2'd1,
    CFG_WINDOW_LEN  = 2'd2,
    CFG_SMOOTH_RATE = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MINAGE,
    ST_DIFF,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_APPLY,
    ST_GATE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;      // capture input energy
    logic minage;    // update min, candidate and age of selected tracker
    logic diff;      // distance from level to target
    logic mul_lo;    // low partial product of the smoothing step
    logic mul_hi;    // high partial product, form step
    logic apply;     // move selected level by step
    logic sel_slow;  // 0: fast tracker, 1: slow tracker
    logic out_load;  // load output register
  } cmd_t;

endpackage

>>> hw/rtl/rmnle_ctrl.sv
module rmnle_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  output logic             m_tvalid_o,
  input  logic             m_tready_i,
  input  logic             gate_pass_i,
  output rmnle_pkg::cmd_t  cmd_o
);
  import rmnle_pkg::*;

  state_e state_q, state_d;
  logic   sel_q, sel_d;
  logic   m_tvalid_q, m_tvalid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      sel_q      <= 1'b0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      sel_q      <= sel_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    sel_d          = sel_q;
    m_tvalid_d     = m_tvalid_q && !m_tready_i;
    cmd_o          = '0;
    cmd_o.sel_slow = sel_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          sel_d      = 1'b0;
          state_d    = ST_MINAGE;
        end
      end
      ST_MINAGE: begin
        cmd_o.minage = 1'b1;
        state_d      = ST_DIFF;
      end
      ST_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = ST_APPLY;
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = sel_q ? ST_DONE : ST_GATE;
      end
      ST_GATE: begin
        // slow tracker runs only when energy is below ten times the new fast level
        if (gate_pass_i) begin
          sel_d   = 1'b1;
          state_d = ST_MINAGE;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_tvalid_q || m_tready_i) begin
          cmd_o.out_load = 1'b1;
          m_tvalid_d     = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign s_tready_o = (state_q == ST_IDLE);
  assign m_tvalid_o = m_tvalid_q;

endmodule

>>> hw/rtl/rmnle_datapath.sv
module rmnle_datapath #(
  parameter int unsigned LEVEL_FRAC_BITS = rmnle_pkg::LEVEL_FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [rmnle_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [rmnle_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i,
  input  logic [rmnle_pkg::ENERGY_BITS-1:0]    energy_i,
  input  rmnle_pkg::cmd_t                      cmd_i,
  output logic                                 gate_pass_o,
  output logic [2*rmnle_pkg::ENERGY_BITS-1:0]  out_data_o
);
  import rmnle_pkg::*;

  localparam int unsigned LW  = ENERGY_BITS + LEVEL_FRAC_BITS;  // level width
  localparam int unsigned HW  = (LW + 1) / 2;                   // low half of multiplicand
  localparam int unsigned LHW = LW - HW;                        // high half
  localparam int unsigned PW  = HW + RATE_BITS;
  localparam int unsigned QW  = LHW + RATE_BITS;
  localparam int unsigned AW  = LW + RATE_BITS;
  localparam int unsigned GW  = LW + 4;                         // holds 10 * level

  // configuration
  logic [ENERGY_BITS-1:0] max_noise_q, min_noise_q;
  logic [WIN_BITS-1:0]    window_len_q;
  logic [RATE_BITS-1:0]   smooth_rate_q;

  // tracker state
  logic [ENERGY_BITS-1:0] fast_min_q, fast_cand_q, slow_min_q, slow_cand_q;
  logic [AGE_BITS-1:0]    fast_age_q, slow_age_q;
  logic [LW-1:0]          fast_level_q, slow_level_q;

  // work registers
  logic [ENERGY_BITS-1:0]     energy_q;
  logic [LW-1:0]              mag_q, step_q;
  logic                       up_q;
  logic [PW-1:0]              prod_q;
  logic [2*ENERGY_BITS-1:0]   out_q;

  logic [ENERGY_BITS-1:0] e_floor, e_sel, cur_min, cur_cand;
  logic [ENERGY_BITS-1:0] nx_min, nx_cand;
  logic [AGE_BITS-1:0]    cur_age, nx_age, half, wl3, three_half;
  logic [LW-1:0]          cur_level, target, new_level;
  logic [RATE_BITS-1:0]   rate;
  logic [QW-1:0]          hi_prod;
  logic [AW-1:0]          acc;
  logic [GW-1:0]          ten_level, e_scaled;

  assign e_floor   = (energy_q < min_noise_q) ? min_noise_q : energy_q;
  assign e_sel     = cmd_i.sel_slow ? e_floor : energy_q;
  assign cur_min   = cmd_i.sel_slow ? slow_min_q : fast_min_q;
  assign cur_cand  = cmd_i.sel_slow ? slow_cand_q : fast_cand_q;
  assign cur_age   = cmd_i.sel_slow ? slow_age_q : fast_age_q;
  assign cur_level = cmd_i.sel_slow ? slow_level_q : fast_level_q;

  // slow window is twice window_len: half = wl, 1.5 windows = 3 * wl
  assign wl3        = AGE_BITS'(window_len_q) + (AGE_BITS'(window_len_q) << 1);
  assign half       = cmd_i.sel_slow ? AGE_BITS'(window_len_q)
                                     : AGE_BITS'(window_len_q >> 1);
  assign three_half = cmd_i.sel_slow ? wl3 : (wl3 >> 1);

  always_comb begin
    nx_min  = cur_min;
    nx_cand = cur_cand;
    if (e_sel < cur_min) begin
      nx_min  = e_sel;
      nx_age  = '0;
      nx_cand = max_noise_q;
    end else begin
      nx_age = cur_age + AGE_BITS'(1);
    end
    if (nx_age > half && e_sel < nx_cand) begin
      nx_cand = e_sel;
    end
    if (nx_age > three_half) begin
      nx_min  = nx_cand;
      nx_cand = max_noise_q;
      nx_age  = half;
    end
  end

  assign target    = {cur_min, LEVEL_FRAC_BITS'(0)};
  assign rate      = (smooth_rate_q > RATE_ONE) ? RATE_ONE : smooth_rate_q;
  assign hi_prod   = QW'(mag_q[LW-1:HW]) * QW'(rate);
  assign acc       = {hi_prod, HW'(0)} + AW'(prod_q);
  assign new_level = up_q ? (cur_level + step_q) : (cur_level - step_q);

  // exact test of energy * 2^F < 10 * fast_level
  assign ten_level   = (GW'(fast_level_q) << 3) + (GW'(fast_level_q) << 1);
  assign e_scaled    = GW'({energy_q, LEVEL_FRAC_BITS'(0)});
  assign gate_pass_o = (e_scaled < ten_level);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_noise_q   <= MAX_NOISE_RST;
      min_noise_q   <= MIN_NOISE_RST;
      window_len_q  <= WINDOW_LEN_RST;
      smooth_rate_q <= SMOOTH_RATE_RST;
      fast_min_q    <= MAX_NOISE_RST;
      fast_cand_q   <= MAX_NOISE_RST;
      fast_age_q    <= '0;
      fast_level_q  <= {MAX_NOISE_RST, LEVEL_FRAC_BITS'(0)};
      slow_min_q    <= MAX_NOISE_RST;
      slow_cand_q   <= MAX_NOISE_RST;
      slow_age_q    <= '0;
      slow_level_q  <= {MAX_NOISE_RST, LEVEL_FRAC_BITS'(0)};
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MAX_NOISE:   max_noise_q   <= cfg_wdata_i[ENERGY_BITS-1:0];
          CFG_MIN_NOISE:   min_noise_q   <= cfg_wdata_i[ENERGY_BITS-1:0];
          CFG_WINDOW_LEN:  window_len_q  <= cfg_wdata_i[WIN_BITS-1:0];
          CFG_SMOOTH_RATE: smooth_rate_q <= cfg_wdata_i[RATE_BITS-1:0];
          default: ;
        endcase
      end
      if (cmd_i.minage) begin
        if (cmd_i.sel_slow) begin
          slow_min_q  <= nx_min;
          slow_cand_q <= nx_cand;
          slow_age_q  <= nx_age;
        end else begin
          fast_min_q  <= nx_min;
          fast_cand_q <= nx_cand;
          fast_age_q  <= nx_age;
        end
      end
      if (cmd_i.apply) begin
        if (cmd_i.sel_slow) begin
          slow_level_q <= new_level;
        end else begin
          fast_level_q <= new_level;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      energy_q <= energy_i;
    end
    if (cmd_i.diff) begin
      up_q  <= (target >= cur_level);
      mag_q <= (target >= cur_level) ? (target - cur_level) : (cur_level - target);
    end
    if (cmd_i.mul_lo) begin
      prod_q <= PW'(mag_q[HW-1:0]) * PW'(rate);
    end
    if (cmd_i.mul_hi) begin
      // floor(mag * rate / 2^15); never exceeds mag
      step_q <= acc[LW+14:15];
    end
    if (cmd_i.out_load) begin
      out_q <= {fast_level_q[LW-1:LEVEL_FRAC_BITS], slow_level_q[LW-1:LEVEL_FRAC_BITS]};
    end
  end

  assign out_data_o = out_q;

endmodule

>>> hw/rtl/running_min_noise_level_estimator_core.sv
// Output valid follows input accept after one pass through the shared update unit when
// the slow tracker is gated off, and after two passes when it runs.
// The input side is blocked while the sequencer works, also while a result waits for the
// output side; the low and high halves of each smoothing multiply are separate states.
// Reset (async, active low) loads default registers and sets all minima to max_noise.
module running_min_noise_level_estimator_core #(
  parameter int unsigned LEVEL_FRAC_BITS = rmnle_pkg::LEVEL_FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [rmnle_pkg::ENERGY_BITS-1:0]    s_axis_tdata_i,   // [31:0] energy
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [2*rmnle_pkg::ENERGY_BITS-1:0]  m_axis_tdata_o,   // [31:0] noise_level,
                                                                 // [63:32] fast_noise_level
  input  logic                                 cfg_we_i,
  input  logic [rmnle_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [rmnle_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i
);
  import rmnle_pkg::*;

  cmd_t cmd;
  logic gate_pass;

  rmnle_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid_i),
    .s_tready_o  (s_axis_tready_o),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .gate_pass_i (gate_pass),
    .cmd_o       (cmd)
  );

  rmnle_datapath #(
    .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .energy_i    (s_axis_tdata_i),
    .cmd_i       (cmd),
    .gate_pass_o (gate_pass),
    .out_data_o  (m_axis_tdata_o)
  );

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted while an item is in progress");

  a_result_returns_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> s_axis_tready_o)
    else $error("result raised without sequencer returning to idle");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("output register overwritten while an item is pending");

endmodule

>>> dv/tb_running_min_noise_level_estimator_core.sv
module tb_running_min_noise_level_estimator_core;
  import rmnle_pkg::*;

  localparam int unsigned FRAC        = LEVEL_FRAC_BITS_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RAND_ITEMS  = 1500;
  localparam int unsigned DIR_ROWS    = 36;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    cfg_idx_e          idx;
    logic [31:0]       val;        // energy or register value
    logic              fixed;      // expected levels typed in below
    logic [31:0]       exp_noise;
    logic [31:0]       exp_fast;
  } row_t;

  typedef struct {
    logic [ENERGY_BITS-1:0] mn;
    logic [ENERGY_BITS-1:0] cand;
    logic [AGE_BITS-1:0]    age;
    logic [63:0]            level;  // 32.16
  } trk_t;

  typedef struct {
    logic [31:0] noise;
    logic [31:0] fast;
  } levels_t;

  logic                            clk_i;
  logic                            rst_ni          = 1'b0;
  logic                            s_axis_tvalid_i = 1'b0;
  logic                            s_axis_tready_o;
  logic [ENERGY_BITS-1:0]          s_axis_tdata_i  = '0;
  logic                            m_axis_tvalid_o;
  logic                            m_axis_tready_i = 1'b0;
  logic [2*ENERGY_BITS-1:0]        m_axis_tdata_o;
  logic                            cfg_we_i        = 1'b0;
  logic [CFG_IDX_BITS-1:0]         cfg_idx_i       = '0;
  logic [CFG_DATA_BITS-1:0]        cfg_wdata_i     = '0;

  // predictor copy of registers and trackers
  logic [ENERGY_BITS-1:0] cfg_max_noise;
  logic [ENERGY_BITS-1:0] cfg_min_noise;
  logic [WIN_BITS-1:0]    cfg_window;
  logic [RATE_BITS-1:0]   cfg_rate;
  trk_t                   fast_trk;
  trk_t                   slow_trk;

  levels_t     level_q[$];
  int unsigned cycle_cnt   = 0;
  int unsigned err_cnt     = 0;
  int unsigned item_cnt    = 0;
  int unsigned result_cnt  = 0;
  int unsigned wr_cnt      = 0;
  int unsigned gated_cnt   = 0;
  int unsigned burst_left  = 0;
  logic [15:0] rcv_cnt     = '0;

  row_t dir_rows [DIR_ROWS] = '{
    '{ROW_ITEM, CFG_MAX_NOISE,   32'd60000000, 1'b1, 32'd60000000, 32'd60000000},
    '{ROW_ITEM, CFG_MAX_NOISE,   32'hFFFFFFFF, 1'b1, 32'd60000000, 32'd60000000},
    '{ROW_ITEM, CFG_MAX_NOISE,   32'd0,        1'b0, 32'd0, 32'd0},
    '{ROW_ITEM, CFG_MAX_NOISE,   32'd5,        1'b0, 32'd0, 32'd0},
    '{ROW_ITEM, CFG_MAX_NOISE,   32'd20,       1'b0, 32'd0, 32'd0},
    '{ROW_CFG,  CFG_SMOOTH_RATE, 32'h0000FFFF, 1'b0, 32'd0, 32'd0},
    '{ROW_ITEM, CFG_MAX_NOISE,   32'd1000,     1'b0, 32'd0, 32'd0},
    '{ROW_ITEM, CFG_MAX_NOISE,   32'd1000,     1'b0, 32'd0, 32'd0},
    '{ROW_CFG,  CFG_SMOOTH_RATE, 32'd0,        1'b0, 32'd0, 32'd0},
    '{ROW_ITEM, CFG_MAX_NOISE,   32'd123456,   1'b0, 32'd0, 32'd0},
    '{ROW_CFG,  CFG_SMOOTH_RATE, 32'h00008000, 1'b0, 32'd0, 32'd0},
    '{ROW_CFG,  CFG_WINDOW_LEN,  32'd0,        1'b0, 32'd0, 32'd0},
    '{ROW_ITEM, CFG_MAX_NOISE,   32'd7,        1'b0, 32'd0, 32'd0},
    '{ROW_ITEM, CFG_MAX_NOISE,   32'd9,        1'b0, 32'd0, 32'd0},
    '{ROW_ITEM, CFG_MAX_NOISE,   32'd3,        1'b0, 32'd0, 32'd0},
    '{ROW_CFG,  CFG_WINDOW_LEN,  32'd1,        1'b0, 32'd0, 32'd0},
    '{ROW_ITEM, CFG_MAX_NOISE,   32'd50,       1'b0, 32'd0, 32'd0},
    '{ROW_ITEM, CFG_MAX_NOISE,   32'd40,       1'b0, 32'd0, 32'd0},
    '{ROW_ITEM, CFG_MAX_NOISE,   32'd60,       1'b0, 32'd0, 32'd0},
    '{ROW_CFG,  CFG_MAX_NOISE,   32'hFFFFFFFF, 1'b0, 32'd0, 32'd0},
    '{ROW_CFG,  CFG_MIN_NOISE,   32'hFFFFFFFF, 1'b0, 32'd0, 32'd0},
    '{ROW_ITEM, CFG_MAX_NOISE,   32'hFFFFFFFF, 1'b0, 32'd0, 32'd0},
    '{ROW_ITEM, CFG_MAX_NOISE,   32'd0,        1'b0, 32'd0, 32'd0},
    '{ROW_CFG,  CFG_MAX_NOISE,   32'd0,        1'b0, 32'd0, 32'd0},
    '{ROW_CFG,  CFG_MIN_NOISE,   32'd0,        1'b0, 32'd0, 32'd0},
    '{ROW_ITEM, CFG_MAX_NOISE,   32'd0,        1'b0, 32'd0, 32'd0},
    '{ROW_ITEM, CFG_MAX_NOISE,   32'd1,        1'b0, 32'd0, 32'd0},
    '{ROW_CFG,  CFG_WINDOW_LEN,  32'hFFFFFFFF, 1'b0, 32'd0, 32'd0},
    '{ROW_ITEM, CFG_MAX_NOISE,   32'h80000000, 1'b0, 32'd0, 32'd0},
    '{ROW_ITEM, CFG_MAX_NOISE,   32'd2,        1'b0, 32'd0, 32'd0},
    '{ROW_CFG,  CFG_WINDOW_LEN,  32'd2,        1'b0, 32'd0, 32'd0},
    '{ROW_ITEM, CFG_MAX_NOISE,   32'hAAAAAAAA, 1'b0, 32'd0, 32'd0},
    '{ROW_ITEM, CFG_MAX_NOISE,   32'h55555555, 1'b0, 32'd0, 32'd0},
    '{ROW_ITEM, CFG_MAX_NOISE,   32'd3,        1'b0, 32'd0, 32'd0},
    '{ROW_ITEM, CFG_MAX_NOISE,   32'd3,        1'b0, 32'd0, 32'd0},
    '{ROW_ITEM, CFG_MAX_NOISE,   32'd3,        1'b0, 32'd0, 32'd0}
  };

  running_min_noise_level_estimator_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic trk_t trk_init();
    trk_t t;
    t.mn    = cfg_max_noise;
    t.cand  = cfg_max_noise;
    t.age   = '0;
    t.level = {32'b0, cfg_max_noise} << FRAC;
    return t;
  endfunction

  // one running-minimum update plus smoothing step toward the minimum
  function automatic trk_t trk_step(trk_t t, logic [ENERGY_BITS-1:0] e, int unsigned win);
    int unsigned half;
    int unsigned three_half;
    int unsigned rate;
    logic [63:0] target;
    logic [63:0] mag;
    logic [63:0] step;
    half       = win >> 1;
    three_half = (3 * win) >> 1;
    rate       = (cfg_rate > RATE_ONE) ? int'(RATE_ONE) : int'(cfg_rate);
    if (e < t.mn) begin
      t.mn   = e;
      t.age  = '0;
      t.cand = cfg_max_noise;
    end else begin
      t.age = t.age + 1'b1;
    end
    if (t.age > half && e < t.cand) t.cand = e;
    if (t.age > three_half) begin
      t.mn   = t.cand;
      t.cand = cfg_max_noise;
      t.age  = AGE_BITS'(half);
    end
    target = {32'b0, t.mn} << FRAC;
    mag    = (target >= t.level) ? target - t.level : t.level - target;
    // truncated step, so the level never overshoots
    step   = (mag >> 15) * 64'(rate) + (((mag & 64'h7FFF) * 64'(rate)) >> 15);
    if (target >= t.level) t.level = t.level + step;
    else t.level = t.level - step;
    return t;
  endfunction

  function automatic levels_t predict_levels(logic [ENERGY_BITS-1:0] e);
    levels_t r;
    logic [ENERGY_BITS-1:0] es;
    fast_trk = trk_step(fast_trk, e, int'(cfg_window));
    // slow tracker only while energy < 10x fast level, compared exactly
    if (({32'b0, e} << FRAC) < fast_trk.level * 64'd10) begin
      es       = (e < cfg_min_noise) ? cfg_min_noise : e;
      slow_trk = trk_step(slow_trk, es, 2 * int'(cfg_window));
    end else begin
      gated_cnt++;
    end
    r.noise = slow_trk.level[FRAC +: 32];
    r.fast  = fast_trk.level[FRAC +: 32];
    return r;
  endfunction

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (level_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_MAX_NOISE:   cfg_max_noise = val;
      CFG_MIN_NOISE:   cfg_min_noise = val;
      CFG_WINDOW_LEN:  cfg_window    = val[WIN_BITS-1:0];
      CFG_SMOOTH_RATE: cfg_rate      = val[RATE_BITS-1:0];
    endcase
    wr_cnt++;
  endtask

  task automatic send_energy(logic [31:0] e, logic fixed, logic [31:0] en, logic [31:0] ef);
    levels_t     lv;
    int unsigned gap;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= e;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    lv = predict_levels(e);
    if (fixed) begin
      lv.noise = en;
      lv.fast  = ef;
    end
    level_q.push_back(lv);
    item_cnt++;
    // bursts of back-to-back items, then a gap of random length, possibly none
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // noise floor with jitter, speech-like bursts and some raw noise
  function automatic logic [31:0] gen_energy(logic [31:0] base);
    case ($urandom_range(0, 19))
      0:       return $urandom();
      1:       return '0;
      2:       return '1;
      3, 4:    return base * $urandom_range(10, 1000);
      5:       return base >> $urandom_range(1, 6);
      default: return base + $urandom_range(0, base / 2 + 1);
    endcase
  endfunction

  task automatic random_phase_cfg();
    logic [31:0] r;
    logic [WIN_BITS-1:0] win;
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 5))
        0:       write_reg(CFG_MAX_NOISE, '0);
        1:       write_reg(CFG_MAX_NOISE, '1);
        2:       write_reg(CFG_MAX_NOISE, $urandom());
        default: write_reg(CFG_MAX_NOISE, $urandom_range(1000, 200000000));
      endcase
    end
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 7))
        0:       write_reg(CFG_MIN_NOISE, '0);
        1:       write_reg(CFG_MIN_NOISE, '1);
        2:       write_reg(CFG_MIN_NOISE, $urandom());
        default: write_reg(CFG_MIN_NOISE, $urandom_range(0, 4096));
      endcase
    end
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 9))
        0:             win = WIN_BITS'($urandom_range(0, 1));
        1:             win = '1;
        2, 3, 4, 5:    win = WIN_BITS'($urandom_range(2, 16));
        6, 7, 8:       win = WIN_BITS'($urandom_range(17, 120));
        default:       win = WINDOW_LEN_RST;
      endcase
      r = $urandom();
      write_reg(CFG_WINDOW_LEN, {r[31:WIN_BITS], win});
    end
    if ($urandom_range(0, 3) != 0) begin
      r = $urandom();
      case ($urandom_range(0, 5))
        0:       r[RATE_BITS-1:0] = '0;
        1:       r[RATE_BITS-1:0] = RATE_ONE;
        2:       r[RATE_BITS-1:0] = RATE_BITS'($urandom_range(32769, 65535));
        default: r[RATE_BITS-1:0] = RATE_BITS'($urandom_range(1, 32767));
      endcase
      write_reg(CFG_SMOOTH_RATE, r);
    end
  endtask

  // receiver: stall mode follows bits [10:9] of a free-running counter
  always @(posedge clk_i) begin
    rcv_cnt <= rcv_cnt + 1'b1;
    case (rcv_cnt[10:9])
      2'd0:    m_axis_tready_i <= 1'b1;
      2'd1:    m_axis_tready_i <= $urandom_range(0, 1);
      2'd2:    m_axis_tready_i <= (rcv_cnt[2:0] == 3'd0);
      default: m_axis_tready_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    levels_t lv;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (level_q.size() == 0) begin
        $display("%0t: unexpected item, expected none, got noise %0d fast %0d", $time,
                 m_axis_tdata_o[31:0], m_axis_tdata_o[63:32]);
        err_cnt++;
      end else begin
        lv = level_q.pop_front();
        result_cnt++;
        if (m_axis_tdata_o[31:0] !== lv.noise) begin
          $display("%0t: noise_level mismatch, expected %0d, got %0d", $time,
                   lv.noise, m_axis_tdata_o[31:0]);
          err_cnt++;
        end
        if (m_axis_tdata_o[63:32] !== lv.fast) begin
          $display("%0t: fast_noise_level mismatch, expected %0d, got %0d", $time,
                   lv.fast, m_axis_tdata_o[63:32]);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d items outstanding", $time, level_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned rnd_items;
    int unsigned n;
    int unsigned dir_items;
    logic [31:0] base;
    cfg_max_noise = MAX_NOISE_RST;
    cfg_min_noise = MIN_NOISE_RST;
    cfg_window    = WINDOW_LEN_RST;
    cfg_rate      = SMOOTH_RATE_RST;
    fast_trk      = trk_init();
    slow_trk      = trk_init();
    rnd_items     = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].kind == ROW_CFG) write_reg(dir_rows[i].idx, dir_rows[i].val);
      else send_energy(dir_rows[i].val, dir_rows[i].fixed, dir_rows[i].exp_noise,
                       dir_rows[i].exp_fast);
    end
    dir_items = item_cnt;

    while (rnd_items < RAND_ITEMS) begin
      random_phase_cfg();
      n    = $urandom_range(60, 250);
      base = $urandom_range(0, 1 << 20);
      for (int k = 0; k < n; k++) begin
        // slow drift of the noise floor
        if ($urandom_range(0, 39) == 0) base = $urandom_range(base / 2, base * 2 + 1);
        if (base > (1 << 22)) base = 1 << 22;
        send_energy(gen_energy(base), 1'b0, '0, '0);
        rnd_items++;
      end
    end

    drain();
    repeat (40) @(posedge clk_i);
    $display("Ran %0d items (%0d directed) across %0d register writes, slow tracker gated %0d times.",
             item_cnt, dir_items, wr_cnt, gated_cnt);
    $display("Checked %0d results, %0d mismatches.", result_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
